// ----- rtl/core/rrk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrk_pkg : shared types and constants for the Rossler RK4 step unit
// Fixed-point limits, register map, sequencer phases, saturation helpers.
// ----------------------------------------------------------------------------
package rrk_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int DATA_W        = 32;
  localparam int STEP_W        = 25;
  localparam int CFG_IDX_W     = 3;
  localparam int PROD_W        = 64;
  // weighted sum of h*k products: |h*k| < 2^56, total weight 6
  localparam int ACC_W         = 61;
  localparam int DIV_BPC       = 8;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_X    = 3'd0,
    REG_INIT_Y    = 3'd1,
    REG_INIT_Z    = 3'd2,
    REG_STEP_SIZE = 3'd3,
    REG_COEF_A    = 3'd4,
    REG_COEF_B    = 3'd5,
    REG_COEF_C    = 3'd6
  } cfg_reg_t;

  localparam logic signed [DATA_W-1:0] INIT_X_RST    = 32'sd3355443;
  localparam logic signed [DATA_W-1:0] INIT_Y_RST    = 32'sd5033165;
  localparam logic signed [DATA_W-1:0] INIT_Z_RST    = 32'sd6710886;
  localparam logic        [STEP_W-1:0] STEP_SIZE_RST = 25'd167772;
  localparam logic signed [DATA_W-1:0] COEF_A_RST    = 32'sd5033165;
  localparam logic signed [DATA_W-1:0] COEF_B_RST    = 32'sd8388608;
  localparam logic signed [DATA_W-1:0] COEF_C_RST    = 32'sd88919245;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_K0,    // dx, issue a*y
    PH_KY,    // dy, issue x*z
    PH_KM,    // hold x*z, issue c*z
    PH_KZ,    // dz, issue h*dx
    PH_SX,    // x stage point / accumulate, issue h*dy
    PH_SY,    // y stage point / accumulate, issue h*dz
    PH_SZ,    // z stage point / accumulate
    PH_DLOAD, // start divide for one lane
    PH_DRUN,
    PH_DWB,   // write new point for one lane
    PH_DONE
  } phase_t;

  localparam logic [1:0] STAGE_K2   = 2'd1;
  localparam logic [1:0] STAGE_K3   = 2'd2;
  localparam logic [1:0] STAGE_LAST = 2'd3;
  localparam logic [1:0] LANE_X     = 2'd0;
  localparam logic [1:0] LANE_Y     = 2'd1;
  localparam logic [1:0] LANE_Z     = 2'd2;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] stage;
    logic [1:0] lane;
  } ctrl_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  localparam logic signed [PROD_W-1:0] MAX32_L = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] MIN32_L = -64'sd2147483648;

  function automatic logic signed [PROD_W-1:0] sx64(input logic signed [DATA_W-1:0] v);
    return {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    if (v > MAX32_L) begin
      r.clip = 1'b1;
      r.val  = MAX32_L[DATA_W-1:0];
    end else if (v < MIN32_L) begin
      r.clip = 1'b1;
      r.val  = MIN32_L[DATA_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/rrk_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrk_mul : shared signed multiplier
// 32x32 signed product, registered, one issue per cycle.
// ----------------------------------------------------------------------------
module rrk_mul (
  input  logic                                clk,
  input  logic signed [rrk_pkg::DATA_W-1:0]   op_a,
  input  logic signed [rrk_pkg::DATA_W-1:0]   op_b,
  output logic signed [rrk_pkg::PROD_W-1:0]   prod
);
  import rrk_pkg::*;

  always_ff @(posedge clk) begin
    prod <= sx64(op_a) * sx64(op_b);
  end

endmodule

// ----- rtl/core/rrk_div3.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrk_div3 : digit-serial divide by three
// Unsigned restoring divide, DIV_BPC quotient bits per cycle.
// ----------------------------------------------------------------------------
module rrk_div3 #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic [W-1:0] quot,
  output logic         busy
);
  import rrk_pkg::*;

  localparam int N_ITER = W / DIV_BPC;
  localparam int CNT_W  = $clog2(N_ITER + 1);

  logic [W-1:0]     num;
  logic [1:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     num_next;
  logic [1:0]       rem_next;

  always_comb begin
    logic [2:0] r3;
    num_next = num;
    rem_next = rem;
    for (int j = 0; j < DIV_BPC; j++) begin
      r3       = {rem_next, num_next[W-1]};
      num_next = {num_next[W-2:0], (r3 >= 3'd3)};
      rem_next = (r3 >= 3'd3) ? 2'(r3 - 3'd3) : r3[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(N_ITER);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign busy = (cnt != '0);
  assign quot = num;

endmodule

// ----- rtl/core/rrk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrk_ctrl : step sequencer
// Walks four RK4 stages of seven phases, then three lane divides.
// ----------------------------------------------------------------------------
module rrk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_ready,
  input  logic           div_busy,
  output rrk_pkg::ctrl_t ctrl
);
  import rrk_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] stage, stage_next;
  logic [1:0] lane, lane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      stage <= '0;
      lane  <= '0;
    end else begin
      phase <= phase_next;
      stage <= stage_next;
      lane  <= lane_next;
    end
  end

  always_comb begin
    phase_next = phase;
    stage_next = stage;
    lane_next  = lane;
    unique case (phase)
      PH_IDLE: begin
        if (in_fire) begin
          phase_next = PH_K0;
          stage_next = '0;
        end
      end
      PH_K0: phase_next = PH_KY;
      PH_KY: phase_next = PH_KM;
      PH_KM: phase_next = PH_KZ;
      PH_KZ: phase_next = PH_SX;
      PH_SX: phase_next = PH_SY;
      PH_SY: phase_next = PH_SZ;
      PH_SZ: begin
        if (stage == STAGE_LAST) begin
          phase_next = PH_DLOAD;
          lane_next  = LANE_X;
        end else begin
          phase_next = PH_K0;
          stage_next = stage + 1'b1;
        end
      end
      PH_DLOAD: phase_next = PH_DRUN;
      PH_DRUN: begin
        if (!div_busy) phase_next = PH_DWB;
      end
      PH_DWB: begin
        if (lane == LANE_Z) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_DLOAD;
          lane_next  = lane + 1'b1;
        end
      end
      PH_DONE: begin
        if (out_ready) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  assign ctrl.phase = phase;
  assign ctrl.stage = stage;
  assign ctrl.lane  = lane;

endmodule

// ----- rtl/core/rossler_rk4_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rossler_rk4_step_unit : one coupled RK4 step of the Rossler system per beat
// Holds the point (x, y, z) and advances it by step h on each input beat.
// ----------------------------------------------------------------------------
// Sequence: RK4 stages (4 stages x 7 phases on one multiplier), then a
//   serial divide-by-six for each of the three lanes, then out_valid.
// The shared multiplier and the serial divider serve one step at a time:
//   a new beat is taken only after out_ready accepts the result. in_ready
//   is low while a step is in flight.
// Reset: synchronous; config registers and point return to their defaults.
// ----------------------------------------------------------------------------
module rossler_rk4_step_unit #(
  parameter int FRAC_BITS = rrk_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [rrk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rrk_pkg::DATA_W-1:0]            cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  restart,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rrk_pkg::DATA_W-1:0]     next_x,
  output logic signed [rrk_pkg::DATA_W-1:0]     next_y,
  output logic signed [rrk_pkg::DATA_W-1:0]     next_z,
  output logic                                  saturated
);
  import rrk_pkg::*;

  // Final increment: floor((acc + 3*2^F) / (6*2^F)) is done as an
  // arithmetic shift by F+1 (width T_W) followed by a floor divide by 3.
  // The divide runs unsigned on t + 3*2^(T_W-1), offset removed afterwards.
  localparam int T_W  = ACC_W - FRAC_BITS - 1;
  localparam int U_W  = T_W + 1;
  localparam int UP_W = ((U_W + DIV_BPC - 1) / DIV_BPC) * DIV_BPC;

  localparam logic signed [ACC_W-1:0]  HALF_DEN = ACC_W'(3) << FRAC_BITS;
  localparam logic        [U_W-1:0]    U_OFS    = U_W'(3) << (T_W - 1);
  localparam logic signed [PROD_W-1:0] INC_OFS  = 64'sd1 <<< (T_W - 1);
  localparam logic signed [PROD_W-1:0] RND_F    = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] RND_H    = 64'sd1 <<< FRAC_BITS;

  // configuration registers
  logic signed [DATA_W-1:0] init_x, init_y, init_z;
  logic        [STEP_W-1:0] step_size;
  logic signed [DATA_W-1:0] coef_a, coef_b, coef_c;

  // point, stage point, current derivatives, x*z hold, RK4 accumulators
  logic signed [DATA_W-1:0] px, py, pz;
  logic signed [DATA_W-1:0] qx, qy, qz;
  logic signed [DATA_W-1:0] kx, ky, kz;
  logic signed [DATA_W-1:0] mxz;
  logic signed [ACC_W-1:0]  acc_x, acc_y, acc_z;
  logic                     clip;

  ctrl_t ctrl;
  logic  in_fire;
  logic  div_busy;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] h32;

  assign in_fire = in_valid && in_ready;
  assign h32     = 32'(step_size);

  // --------------------------------------------------------------------------
  // sequencer, shared multiplier, divider
  // --------------------------------------------------------------------------
  rrk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_ready (out_ready),
    .div_busy  (div_busy),
    .ctrl      (ctrl)
  );

  // Operand issue: the product is used in the phase after the one that
  // selects it, so each phase issues what the next phase consumes.
  always_comb begin
    unique case (ctrl.phase)
      PH_K0:   begin mul_a = coef_a; mul_b = qy; end
      PH_KY:   begin mul_a = qx;     mul_b = qz; end
      PH_KM:   begin mul_a = coef_c; mul_b = qz; end
      PH_KZ:   begin mul_a = h32;    mul_b = kx; end
      PH_SX:   begin mul_a = h32;    mul_b = ky; end
      PH_SY:   begin mul_a = h32;    mul_b = kz; end
      default: begin mul_a = coef_a; mul_b = qy; end
    endcase
  end

  rrk_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  logic [UP_W-1:0] div_in, div_quot;

  rrk_div3 #(
    .W (UP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.phase == PH_DLOAD),
    .dividend (div_in),
    .quot     (div_quot),
    .busy     (div_busy)
  );

  // --------------------------------------------------------------------------
  // arithmetic around the product
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] rnd_f, rnd_h;
  sat_t                     r_f, r_h, r_s;
  sat_t                     kx_s, ky_s, kz_s, q_s, n_s;
  logic [1:0]               idx;
  logic signed [DATA_W-1:0] p_sel;
  logic signed [ACC_W-1:0]  acc_sel, acc_term, acc_sum, prod_acc;
  logic signed [ACC_W-1:0]  tsum, tshift;
  logic        [U_W-1:0]    u_val;
  logic signed [PROD_W-1:0] inc;
  logic                     upd_q, wgt2;

  // round half up: add 2^(s-1), floor shift by s; s = F or F+1 (half step)
  assign rnd_f = (prod + RND_F) >>> FRAC_BITS;
  assign rnd_h = (prod + RND_H) >>> (FRAC_BITS + 1);
  assign r_f   = sat32(rnd_f);
  assign r_h   = sat32(rnd_h);
  // third stage takes the full step, the first two the half step
  assign r_s   = (ctrl.stage == STAGE_K3) ? r_f : r_h;

  // derivatives at the stage point
  assign kx_s = sat32(-sx64(qy) - sx64(qz));
  assign ky_s = sat32(sx64(qx) + sx64(r_f.val));
  assign kz_s = sat32(sx64(coef_b) + sx64(mxz) - sx64(r_f.val));

  // lane pick: stage phases go x, y, z; the divide phases follow ctrl.lane
  always_comb begin
    unique case (ctrl.phase)
      PH_SX:   idx = LANE_X;
      PH_SY:   idx = LANE_Y;
      PH_SZ:   idx = LANE_Z;
      default: idx = ctrl.lane;
    endcase
  end

  always_comb begin
    case (idx)
      LANE_X:  begin p_sel = px; acc_sel = acc_x; end
      LANE_Y:  begin p_sel = py; acc_sel = acc_y; end
      default: begin p_sel = pz; acc_sel = acc_z; end
    endcase
  end

  // no stage point after k4; k2 and k3 count twice
  assign upd_q    = (ctrl.stage != STAGE_LAST);
  assign wgt2     = (ctrl.stage == STAGE_K2) || (ctrl.stage == STAGE_K3);
  assign q_s      = sat32(sx64(p_sel) + sx64(r_s.val));
  assign prod_acc = prod[ACC_W-1:0];
  assign acc_term = wgt2 ? (prod_acc <<< 1) : prod_acc;
  assign acc_sum  = acc_sel + acc_term;

  // final increment
  assign tsum   = acc_sel + HALF_DEN;
  assign tshift = tsum >>> (FRAC_BITS + 1);
  assign u_val  = tshift[U_W-1:0] + U_OFS;
  assign div_in = UP_W'(u_val);
  assign inc    = $signed(64'(div_quot[U_W-1:0])) - INC_OFS;
  assign n_s    = sat32(sx64(p_sel) + inc);

  // --------------------------------------------------------------------------
  // config registers, point and clip flag
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      init_x    <= INIT_X_RST;
      init_y    <= INIT_Y_RST;
      init_z    <= INIT_Z_RST;
      step_size <= STEP_SIZE_RST;
      coef_a    <= COEF_A_RST;
      coef_b    <= COEF_B_RST;
      coef_c    <= COEF_C_RST;
      px        <= INIT_X_RST;
      py        <= INIT_Y_RST;
      pz        <= INIT_Z_RST;
      clip      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INIT_X:    init_x    <= cfg_data;
          REG_INIT_Y:    init_y    <= cfg_data;
          REG_INIT_Z:    init_z    <= cfg_data;
          REG_STEP_SIZE: step_size <= cfg_data[STEP_W-1:0];
          REG_COEF_A:    coef_a    <= cfg_data;
          REG_COEF_B:    coef_b    <= cfg_data;
          REG_COEF_C:    coef_c    <= cfg_data;
          default:       ;
        endcase
      end
      unique case (ctrl.phase)
        PH_IDLE: begin
          if (in_fire) begin
            clip <= 1'b0;
            if (restart) begin
              px <= init_x;
              py <= init_y;
              pz <= init_z;
            end
          end
        end
        PH_K0:  clip <= clip | kx_s.clip;
        PH_KY:  clip <= clip | r_f.clip | ky_s.clip;
        PH_KM:  clip <= clip | r_f.clip;
        PH_KZ:  clip <= clip | r_f.clip | kz_s.clip;
        PH_SX, PH_SY, PH_SZ: begin
          if (upd_q) clip <= clip | r_s.clip | q_s.clip;
        end
        PH_DWB: begin
          clip <= clip | n_s.clip;
          case (ctrl.lane)
            LANE_X:  px <= n_s.val;
            LANE_Y:  py <= n_s.val;
            default: pz <= n_s.val;
          endcase
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // working registers (no reset: loaded at the start of each step)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (ctrl.phase)
      PH_IDLE: begin
        // first stage evaluates at the (possibly reloaded) point
        if (in_fire) begin
          qx    <= restart ? init_x : px;
          qy    <= restart ? init_y : py;
          qz    <= restart ? init_z : pz;
          acc_x <= '0;
          acc_y <= '0;
          acc_z <= '0;
        end
      end
      PH_K0: kx  <= kx_s.val;
      PH_KY: ky  <= ky_s.val;
      PH_KM: mxz <= r_f.val;
      PH_KZ: kz  <= kz_s.val;
      PH_SX: begin
        acc_x <= acc_sum;
        if (upd_q) qx <= q_s.val;
      end
      PH_SY: begin
        acc_y <= acc_sum;
        if (upd_q) qy <= q_s.val;
      end
      PH_SZ: begin
        acc_z <= acc_sum;
        if (upd_q) qz <= q_s.val;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake and result: the point registers double as the output register
  // --------------------------------------------------------------------------
  assign in_ready  = (ctrl.phase == PH_IDLE);
  assign out_valid = (ctrl.phase == PH_DONE);
  assign next_x    = px;
  assign next_y    = py;
  assign next_z    = pz;
  assign saturated = clip;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a step in flight blocks the next beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken again while a step is running");

  // the lane write-back only follows a finished divide
  a_div_done_on_wb: assert property (@(posedge clk) disable iff (rst)
    (ctrl.phase == PH_DWB) |-> !div_busy)
    else $error("write-back while divider still busy");

  // restart reloads the point before the step
  a_restart_load: assert property (@(posedge clk) disable iff (rst)
    (in_fire && restart) |=> (px == $past(init_x)) && (pz == $past(init_z)))
    else $error("restart did not reload the point");

  // clip flag starts clear for every step
  a_clip_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !saturated)
    else $error("clip flag carried over from previous step");

endmodule

// ----- tb/rk4_step_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4_step_checker : prediction and in-order check for the Rossler RK4 unit
// Watches the register write port and both beat channels. It keeps its own
// copy of the registers and the point, works out each new point on an input
// beat and compares every output beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module rk4_step_checker
  import rrk_pkg::*;
#(
  parameter int FRAC = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     restart,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] next_x,
  input  logic signed [DATA_W-1:0] next_y,
  input  logic signed [DATA_W-1:0] next_z,
  input  logic                     saturated,
  output int                       fail_count,
  output int                       results_seen
);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic                     sat;
  } rk_point_t;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  logic signed [DATA_W-1:0] ini_x, ini_y, ini_z;
  logic signed [DATA_W-1:0] coef_a, coef_b, coef_c;
  logic        [STEP_W-1:0] step_h;
  longint                   pos_x, pos_y, pos_z;
  rk_point_t                due_points[$];

  function automatic longint clamp_word(input longint v, inout bit clip);
    if (v > WORD_MAX) begin
      clip = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      clip = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // round half up, then drop s fraction bits
  function automatic longint fx_mul(input longint l, input longint r, input int s,
                                    inout bit clip);
    longint prod;
    prod = l * r + (longint'(1) <<< (s - 1));
    return clamp_word(prod >>> s, clip);
  endfunction

  function automatic longint floor_div(input longint num, input longint d);
    if (num >= 0) return num / d;
    return -((-(num + 1)) / d) - 1;
  endfunction

  function automatic void rossler_rates(input longint px, input longint py,
                                        input longint pz, output longint dx,
                                        output longint dy, output longint dz,
                                        inout bit clip);
    longint ay, xz, cz;
    dx = clamp_word(-py - pz, clip);
    ay = fx_mul(longint'(coef_a), py, FRAC, clip);
    dy = clamp_word(px + ay, clip);
    xz = fx_mul(px, pz, FRAC, clip);
    cz = fx_mul(longint'(coef_c), pz, FRAC, clip);
    dz = clamp_word(longint'(coef_b) + xz - cz, clip);
  endfunction

  // one coupled RK4 step from the held point; updates the point
  function automatic rk_point_t rk4_advance(input logic reload);
    bit        clip;
    int        i;
    longint    h, den, wsum, incr, dh;
    longint    p[3], q[3], nxt[3];
    longint    k1[3], k2[3], k3[3], k4[3];
    rk_point_t res;
    clip = 1'b0;
    h    = longint'(step_h);
    den  = longint'(6) <<< FRAC;
    if (reload) begin
      pos_x = ini_x;
      pos_y = ini_y;
      pos_z = ini_z;
    end
    p[0] = pos_x;
    p[1] = pos_y;
    p[2] = pos_z;
    rossler_rates(p[0], p[1], p[2], k1[0], k1[1], k1[2], clip);
    for (i = 0; i < 3; i++) begin
      dh   = fx_mul(h, k1[i], FRAC + 1, clip);
      q[i] = clamp_word(p[i] + dh, clip);
    end
    rossler_rates(q[0], q[1], q[2], k2[0], k2[1], k2[2], clip);
    for (i = 0; i < 3; i++) begin
      dh   = fx_mul(h, k2[i], FRAC + 1, clip);
      q[i] = clamp_word(p[i] + dh, clip);
    end
    rossler_rates(q[0], q[1], q[2], k3[0], k3[1], k3[2], clip);
    for (i = 0; i < 3; i++) begin
      dh   = fx_mul(h, k3[i], FRAC, clip);
      q[i] = clamp_word(p[i] + dh, clip);
    end
    rossler_rates(q[0], q[1], q[2], k4[0], k4[1], k4[2], clip);
    for (i = 0; i < 3; i++) begin
      wsum   = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
      incr   = floor_div(h * wsum + den / 2, den);
      nxt[i] = clamp_word(p[i] + incr, clip);
    end
    pos_x   = nxt[0];
    pos_y   = nxt[1];
    pos_z   = nxt[2];
    res.x   = DATA_W'(nxt[0]);
    res.y   = DATA_W'(nxt[1]);
    res.z   = DATA_W'(nxt[2]);
    res.sat = clip;
    return res;
  endfunction

  always @(posedge clk) begin
    rk_point_t want;
    if (rst) begin
      ini_x  = INIT_X_RST;
      ini_y  = INIT_Y_RST;
      ini_z  = INIT_Z_RST;
      step_h = STEP_SIZE_RST;
      coef_a = COEF_A_RST;
      coef_b = COEF_B_RST;
      coef_c = COEF_C_RST;
      pos_x  = INIT_X_RST;
      pos_y  = INIT_Y_RST;
      pos_z  = INIT_Z_RST;
      due_points.delete();
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_X:    ini_x  = cfg_data;
          REG_INIT_Y:    ini_y  = cfg_data;
          REG_INIT_Z:    ini_z  = cfg_data;
          REG_STEP_SIZE: step_h = cfg_data[STEP_W-1:0];
          REG_COEF_A:    coef_a = cfg_data;
          REG_COEF_B:    coef_b = cfg_data;
          REG_COEF_C:    coef_c = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (due_points.size() == 0) begin
          $error("result beat with no step pending: x=%0d y=%0d z=%0d",
                 next_x, next_y, next_z);
          fail_count++;
        end else begin
          want = due_points.pop_front();
          if (next_x !== want.x) begin
            $error("next_x: expected %0d, got %0d", want.x, next_x);
            fail_count++;
          end
          if (next_y !== want.y) begin
            $error("next_y: expected %0d, got %0d", want.y, next_y);
            fail_count++;
          end
          if (next_z !== want.z) begin
            $error("next_z: expected %0d, got %0d", want.z, next_z);
            fail_count++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, saturated);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) due_points.push_back(rk4_advance(restart));
    end
  end

endmodule

// ----- tb/tb_rossler_rk4_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rossler_rk4_step_unit : stimulus and verdict for the Rossler RK4 unit
// Drives directed corner settings, then randomised register phases with
// bursty input beats and a stalling receiver; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_rossler_rk4_step_unit;
  import rrk_pkg::*;

  localparam int TOTAL_ITEMS  = 1550;
  localparam int PAUSE_CYCLES = 4;    // settle time before register writes
  localparam int DRAIN_CYCLES = 60;   // time for stray beats after the drain
  localparam int LONG_HOLD    = 700;  // receiver hold-off, in cycles

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // unmapped index
  localparam logic [DATA_W-1:0]    W_MAX    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]    W_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0]    Q_ONE    = 32'd16777216;  // 1.0 in Q8.24

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic                     restart   = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] next_x, next_y, next_z;
  logic                     saturated;

  int fail_count;
  int results_seen;
  int steps_sent = 0;
  int hold_asks  = 0;   // bumped to ask the receiver for a long hold-off

  rossler_rk4_step_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .next_x    (next_x),
    .next_y    (next_y),
    .next_z    (next_z),
    .saturated (saturated)
  );

  rk4_step_checker step_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_x       (next_x),
    .next_y       (next_y),
    .next_z       (next_z),
    .saturated    (saturated),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: the slowest legal run is well under 3 ms.
  initial begin
    #15ms;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: its own stall pattern - long ready stretches, coin-flip ready,
  // short stalls - plus a long hold-off whenever the stimulus asks for one.
  // During a hold-off the unit keeps its result, drops in_ready, and the
  // sender sits there offering the next beat.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int span;
    int served;
    served = 0;
    forever begin
      if (hold_asks != served) begin
        served = hold_asks;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_ready <= 1'b1;
            repeat ($urandom_range(20, 300)) @(posedge clk);
          end
          1: begin
            span = $urandom_range(20, 150);
            repeat (span) begin
              out_ready <= 1'($urandom_range(0, 1));
              @(posedge clk);
            end
          end
          2: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge clk);
          end
          default: begin
            out_ready <= 1'b1;
            @(posedge clk);
          end
        endcase
      end
    end
  end

  // One input beat; valid stays up until the unit takes it.
  task automatic send_step(input logic reload);
    in_valid <= 1'b1;
    restart  <= reload;
    do @(posedge clk); while (!in_ready);
    steps_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Reprogram all registers once the unit has drained. The caller must
  // already have dropped in_valid. A stray write to the unmapped index goes
  // in the middle; it must change nothing.
  task automatic write_regs(input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
                            input logic [DATA_W-1:0] vz, input logic [DATA_W-1:0] vh,
                            input logic [DATA_W-1:0] va, input logic [DATA_W-1:0] vb,
                            input logic [DATA_W-1:0] vc);
    wait (results_seen == steps_sent);
    repeat (PAUSE_CYCLES) @(posedge clk);
    write_reg(REG_INIT_X, vx);
    write_reg(REG_INIT_Y, vy);
    write_reg(REG_INIT_Z, vz);
    write_reg(REG_NONE, $urandom);
    write_reg(REG_STEP_SIZE, vh);
    write_reg(REG_COEF_A, va);
    write_reg(REG_COEF_B, vb);
    write_reg(REG_COEF_C, vc);
    cfg_we <= 1'b0;
  endtask

  // Random stretch of beats in bursts with random gaps. The first beat
  // reloads the start point; afterwards a restart comes 1 time in odds.
  task automatic run_steps(input int count, input int odds);
    int left, burst, gap, i;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      for (i = 0; i < burst; i++)
        send_step((left == count && i == 0) || ($urandom_range(1, odds) == 1));
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (gap == 0) in_valid <= 1'b0;
  endtask

  // start point within +/-8.0, where the attractor lives
  function automatic logic [DATA_W-1:0] rand_coord();
    return $urandom_range(0, 268435456) - 134217728;
  endfunction

  function automatic logic [DATA_W-1:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return '1;
      default: return 32'd1;
    endcase
  endfunction

  // all-ones data lands as the largest 25-bit step, well above 1.0
  function automatic logic [DATA_W-1:0] extreme_h();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return Q_ONE;
      2:       return '1;
      default: return 32'd1;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph, n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Defaults straight out of reset: the point starts at the init values,
    // then a restart mid-run reloads them.
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    in_valid <= 1'b0;

    // Everything at full scale with h = 1.0: clips all over the place.
    write_regs(W_MAX, W_MIN, W_MAX, Q_ONE, W_MAX, W_MIN, W_MIN);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    in_valid <= 1'b0;

    // Zero step: point must not move, even with clipping derivatives.
    write_regs(rand_coord(), rand_coord(), rand_coord(), '0, W_MIN, W_MAX, W_MAX);
    send_step(1'b1);
    send_step(1'b0);
    in_valid <= 1'b0;

    // Step above 1.0 (junk in the upper data bits too), most negative start.
    write_regs(W_MIN, W_MIN, W_MIN, '1, '1, '0, 32'd1);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    in_valid <= 1'b0;

    // All-zero system: fixed point at the origin.
    write_regs('0, '0, '0, 32'd167772, '0, '0, '0);
    send_step(1'b1);
    send_step(1'b0);
    in_valid <= 1'b0;

    // Back to the reset settings.
    write_regs(INIT_X_RST, INIT_Y_RST, INIT_Z_RST, 32'(STEP_SIZE_RST),
               COEF_A_RST, COEF_B_RST, COEF_C_RST);
    send_step(1'b1);
    in_valid <= 1'b0;

    // Random phases: mostly well-behaved attractor settings with long
    // trajectories, some fully random and some corner-value settings.
    for (ph = 0; steps_sent < TOTAL_ITEMS; ph++) begin
      case (ph % 5)
        3: begin
          write_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
          n = 60;
          run_steps((n < TOTAL_ITEMS - steps_sent) ? n : TOTAL_ITEMS - steps_sent, 3);
        end
        4: begin
          write_regs(extreme_word(), extreme_word(), extreme_word(), extreme_h(),
                     extreme_word(), extreme_word(), extreme_word());
          n = 30;
          run_steps((n < TOTAL_ITEMS - steps_sent) ? n : TOTAL_ITEMS - steps_sent, 2);
        end
        default: begin
          write_regs(rand_coord(), rand_coord(), rand_coord(),
                     {7'($urandom), 25'($urandom_range(16777, 838861))},
                     $urandom_range(1677722, 6710886),
                     $urandom_range(1677722, 16777216),
                     $urandom_range(33554432, 167772160));
          // hold-off asked only once drained, so the long run that follows
          // keeps offering beats into the stalled unit
          if (ph == 1 || ph == 7) hold_asks++;
          n = 150;
          run_steps((n < TOTAL_ITEMS - steps_sent) ? n : TOTAL_ITEMS - steps_sent, 40);
        end
      endcase
    end

    // Drain, then give any stray beat time to show up.
    wait (results_seen == steps_sent);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
